// ===== rtl/bounded_list_deque_engine_top_macros.svh =====
// Assertion macros shared by the deque engine RTL.
`ifndef BOUNDED_LIST_DEQUE_ENGINE_TOP_MACROS_SVH
`define BOUNDED_LIST_DEQUE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off during reset.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdq_pkg.sv =====
// Types and constants of the bounded deque engine.
package bdq_pkg;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned AMOUNT_W  = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LENGTH_W  = 8;
  localparam int unsigned STATUS_W  = 2;

  localparam int unsigned DEPTH_DEF      = 128;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_READ_FRONT = 3'd3,
    OP_READ_INDEX = 3'd4,
    OP_TAKE       = 3'd5,
    OP_DROP       = 3'd6,
    OP_QUERY      = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

// ===== rtl/bdq_if.sv =====
// Request and response channels of the bounded deque engine.
interface bdq_in_if;
  logic                          valid;
  logic                          ready;
  logic [bdq_pkg::OPCODE_W-1:0]  opcode;
  logic [bdq_pkg::VALUE_W-1:0]   value;
  logic [bdq_pkg::AMOUNT_W-1:0]  amount;

  modport source (output valid, output opcode, output value, output amount, input ready);
  modport sink   (input valid, input opcode, input value, input amount, output ready);
endinterface

interface bdq_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdq_pkg::DATA_W-1:0]    data;
  logic [bdq_pkg::LENGTH_W-1:0]  length;
  logic                          empty_flag;
  logic [bdq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output data, output length, output empty_flag, output status,
                  input ready);
  modport sink   (input valid, input data, input length, input empty_flag, input status,
                  output ready);
endinterface

// ===== rtl/bounded_list_deque_engine_top.sv =====
// Bounded deque engine: ring-buffer list with one result per request.
//
// A list of up to DEPTH elements lives in a ring buffer (front pointer plus
// element count). Every request transfer carries one opcode (push front, push
// back, pop front, read front, read index, take first n, drop first n, query)
// and produces exactly one response transfer with the read data, the length
// after the operation, an empty flag and a status. Throughput is one request
// per clock cycle unless the output stalls; each response is valid in the
// cycle after its request. The rate is set by the pointer/count update and
// the synchronous memory port: on each request transfer the engine writes at
// most one slot, reads one slot into a registered read-data stage, and
// updates front and count, all in the same edge. A single response register
// decouples the two sides; the request side is ready whenever that register
// is empty or is being drained in the same cycle. Refusals (push when full,
// read/pop when empty, index out of range, take beyond the length) leave the
// list as is and report a nonzero status. Slot contents are not cleared by
// reset; only positions below the count, all written, are ever returned.
`include "bounded_list_deque_engine_top_macros.svh"

module bounded_list_deque_engine_top #(
  parameter int unsigned DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = bdq_pkg::ELEM_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bdq_in_if.sink        req_i,
  bdq_out_if.source     rsp_o
);

  // Pointer, count and sum widths.
  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CMPW = (CW > bdq_pkg::AMOUNT_W) ? CW : bdq_pkg::AMOUNT_W;
  // Bits carried between the 32-bit ports and the stored element.
  localparam int unsigned CPW  = (ELEM_WIDTH < bdq_pkg::VALUE_W) ? ELEM_WIDTH
                                                                   : bdq_pkg::VALUE_W;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [PW-1:0]          front_q, front_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [ELEM_WIDTH-1:0]  mem_q [DEPTH];
  logic [ELEM_WIDTH-1:0]  mem_rd_q;

  // Response register
  logic                   out_vld_q, out_vld_d;
  logic                   rd_ok_q;
  logic [CW-1:0]          out_cnt_q;
  bdq_pkg::status_e       out_st_q;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic                   acc;
  bdq_pkg::op_e           op;
  logic                   list_empty, is_full;
  logic                   n_gt, n_ge;
  logic [CW-1:0]          n_cw, drop_n, offset;
  logic [SW-1:0]          sum;
  logic [PW-1:0]          ring_pos, front_dec;
  logic                   wr_en, rd_ok;
  logic [ELEM_WIDTH-1:0]  wr_data;
  bdq_pkg::status_e       st;

  assign req_i.ready = !out_vld_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign op          = bdq_pkg::op_e'(req_i.opcode);

  assign list_empty = (cnt_q == '0);
  assign is_full    = (cnt_q == CW'(DEPTH));
  assign n_gt       = CMPW'(req_i.amount) >  CMPW'(cnt_q);
  assign n_ge       = CMPW'(req_i.amount) >= CMPW'(cnt_q);
  // Only used where amount does not exceed the count, so it fits in CW bits.
  assign n_cw       = CW'(req_i.amount);
  assign drop_n     = n_gt ? cnt_q : n_cw;

  // One shared adder: front + offset, wrapped once (sum < 2*DEPTH wherever the result is used).
  always_comb begin
    case (op)
      bdq_pkg::OP_PUSH_BACK:  offset = cnt_q;
      bdq_pkg::OP_POP_FRONT:  offset = CW'(1);
      bdq_pkg::OP_READ_INDEX: offset = n_cw;
      bdq_pkg::OP_DROP:       offset = drop_n;
      default:                offset = '0;
    endcase
  end

  assign sum       = SW'(front_q) + SW'(offset);
  assign ring_pos  = (sum >= SW'(DEPTH)) ? PW'(sum - SW'(DEPTH)) : PW'(sum);
  assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : (front_q - PW'(1));

  always_comb begin
    wr_data = '0;
    wr_data[CPW-1:0] = req_i.value[CPW-1:0];
  end

  // Next state and status
  always_comb begin
    front_d = front_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    rd_ok   = 1'b0;
    st      = bdq_pkg::ST_OK;
    unique case (op) inside
      bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          st = bdq_pkg::ST_FULL;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CW'(1);
          if (op == bdq_pkg::OP_PUSH_FRONT) begin
            front_d = front_dec;
          end
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (list_empty) begin
          st = bdq_pkg::ST_EMPTY;
        end else begin
          front_d = ring_pos;
          cnt_d   = cnt_q - CW'(1);
        end
      end
      bdq_pkg::OP_READ_FRONT: begin
        if (list_empty) st = bdq_pkg::ST_EMPTY;
        else            rd_ok = 1'b1;
      end
      bdq_pkg::OP_READ_INDEX: begin
        if (list_empty) st = bdq_pkg::ST_EMPTY;
        else if (n_ge)  st = bdq_pkg::ST_RANGE;
        else            rd_ok = 1'b1;
      end
      bdq_pkg::OP_TAKE: begin
        if (n_gt) st = bdq_pkg::ST_RANGE;
        else      cnt_d = n_cw;
      end
      bdq_pkg::OP_DROP: begin
        front_d = ring_pos;
        cnt_d   = cnt_q - drop_n;
      end
      bdq_pkg::OP_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Slot memory: at most one write and one registered read per transfer.
  // Push front writes below the old front; the read address is ring_pos,
  // which is the front itself for read front (offset zero).
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (acc && wr_en) begin
      mem_q[(op == bdq_pkg::OP_PUSH_FRONT) ? front_dec : ring_pos] <= wr_data;
    end
    if (acc) begin
      mem_rd_q <= mem_q[ring_pos];
    end
  end

  // ---------------------------------------------------------------------------
  // Control state and response register
  // ---------------------------------------------------------------------------
  always_comb begin
    if (acc)              out_vld_d = 1'b1;
    else if (rsp_o.ready) out_vld_d = 1'b0;
    else                  out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (acc) begin
        front_q <= front_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_ok_q   <= rd_ok;
      out_cnt_q <= cnt_d;
      out_st_q  <= st;
    end
  end

  always_comb begin
    rsp_o.data = '0;
    if (rd_ok_q) begin
      rsp_o.data[CPW-1:0] = mem_rd_q[CPW-1:0];
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.length     = bdq_pkg::LENGTH_W'(out_cnt_q);
  assign rsp_o.empty_flag = (out_cnt_q == '0);
  assign rsp_o.status     = out_st_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BDQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "count exceeds depth")
  `BDQ_ASSERT_NOW(a_rsp_len_tracks, out_vld_q, out_cnt_q == cnt_q,
                  "response length differs from live count")
  `BDQ_ASSERT_NEXT(a_full_refused,
                   acc && is_full &&
                   (op == bdq_pkg::OP_PUSH_FRONT || op == bdq_pkg::OP_PUSH_BACK),
                   $stable(cnt_q) && $stable(front_q) && out_st_q == bdq_pkg::ST_FULL,
                   "push to full list changed state")
  `BDQ_ASSERT_NEXT(a_pop_dec, acc && !list_empty && op == bdq_pkg::OP_POP_FRONT,
                   cnt_q == $past(cnt_q) - CW'(1), "pop did not shrink the list")

endmodule
